// ----- hdl/mbrtu_pkg.sv -----
`default_nettype none

package mbrtu_pkg;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_READ      = 2'd1,
    OP_RESP_BYTE = 2'd2,
    OP_RESP_END  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_INVALID = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_TX
  } state_e;

  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [7:0]  FUNC_WRITE   = 8'h06;
  localparam logic [15:0] READ_COUNT   = 16'h0001;
  localparam logic [7:0]  RESP_DATA_BYTES = 8'h02;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_SEED     = 16'hFFFF;
  localparam logic [7:0]  SLAVE_RESET  = 8'h01;

  // CRC-16 (reflected) advanced by one byte, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/modbus_rtu_register_frame_engine.sv -----
// Modbus RTU master frame engine.
// Input channel (in_valid_i / in_stall_o) carries one word per request or response event:
// a write or read request, one received response byte, or the end of a response.
// Output channel (out_valid_o / out_stall_i) carries the result words.
// A request produces eight transmit words (address, function, register address,
// data, CRC high then low); the first appears in the output register in the cycle
// after acceptance and the rest follow one per cycle while the receiver does not stall.
// The frame is held in a five-byte shift register and the CRC advances one byte
// per cycle as the bytes move out, unless the receiver stalls.
// A response byte is absorbed and produces no word; end of response
// produces one word in the cycle after acceptance.
// When the receiver stalls, the output register holds its word and the engine
// stops both its frame sequence and the input channel until the word is taken.
// Reset clears the response capture, seeds the CRC, sets the slave address to 1
// and empties the output register. cfg_we_i writes the slave address.
`default_nettype none

module modbus_rtu_register_frame_engine #(
  parameter int RESPONSE_LIMIT = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [7:0]         cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         op_i,
  input  wire  [15:0]        register_address_i,
  input  wire  signed [15:0] write_value_i,
  input  wire  [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         tx_byte_o,
  output logic signed [15:0] read_value_o,
  output logic               last_o
);
  import mbrtu_pkg::*;

  localparam int CntW = $clog2(RESPONSE_LIMIT + 1);

  state_e          state_q, state_d;
  logic [2:0]      tx_cnt_q, tx_cnt_d;
  logic [39:0]     tx_sh_q, tx_sh_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      slave_q;
  logic [CntW-1:0] resp_cnt_q, resp_cnt_d;
  logic [7:0]      resp_func_q, resp_func_d;
  logic [7:0]      resp_bcnt_q, resp_bcnt_d;
  logic [15:0]     resp_data_q, resp_data_d;
  logic            out_valid_q, out_valid_d;
  kind_e           out_kind_q, out_kind_d;
  logic [7:0]      out_tx_q, out_tx_d;
  logic [15:0]     out_val_q, out_val_d;
  logic            out_last_q, out_last_d;

  logic            out_free;
  logic            in_accept;
  logic [7:0]      func;
  logic [15:0]     data;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    tx_cnt_d    = tx_cnt_q;
    tx_sh_d     = tx_sh_q;
    crc_d       = crc_q;
    resp_cnt_d  = resp_cnt_q;
    resp_func_d = resp_func_q;
    resp_bcnt_d = resp_bcnt_q;
    resp_data_d = resp_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_tx_d    = out_tx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    func        = (op_e'(op_i) == OP_WRITE) ? FUNC_WRITE : FUNC_READ;
    data        = (op_e'(op_i) == OP_WRITE) ? $unsigned(write_value_i) : READ_COUNT;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_e'(op_i))
            OP_WRITE, OP_READ: begin
              // The address byte goes out now; the other five wait in the shift register.
              tx_sh_d     = {func, register_address_i, data};
              crc_d       = crc_byte(CRC_SEED, slave_q);
              out_valid_d = 1'b1;
              out_kind_d  = KIND_TX;
              out_tx_d    = slave_q;
              out_val_d   = 16'h0000;
              out_last_d  = 1'b0;
              tx_cnt_d    = 3'd1;
              state_d     = ST_TX;
              resp_cnt_d  = '0;
              resp_func_d = 8'h00;
              resp_bcnt_d = 8'h00;
              resp_data_d = 16'h0000;
            end
            OP_RESP_BYTE: begin
              if (resp_cnt_q < CntW'(RESPONSE_LIMIT)) begin
                if (resp_cnt_q == CntW'(1)) resp_func_d = rx_byte_i;
                if (resp_cnt_q == CntW'(2)) resp_bcnt_d = rx_byte_i;
                if (resp_cnt_q == CntW'(3)) resp_data_d[15:8] = rx_byte_i;
                if (resp_cnt_q == CntW'(4)) resp_data_d[7:0] = rx_byte_i;
                resp_cnt_d = resp_cnt_q + CntW'(1);
              end
            end
            OP_RESP_END: begin
              out_valid_d = 1'b1;
              out_tx_d    = 8'h00;
              out_last_d  = 1'b1;
              if (resp_cnt_q >= CntW'(5) && resp_func_q == FUNC_READ &&
                  resp_bcnt_q == RESP_DATA_BYTES) begin
                out_kind_d = KIND_VALUE;
                out_val_d  = resp_data_q;
              end else begin
                out_kind_d = KIND_INVALID;
                out_val_d  = 16'h0000;
              end
              resp_cnt_d  = '0;
              resp_func_d = 8'h00;
              resp_bcnt_d = 8'h00;
              resp_data_d = 16'h0000;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_TX;
          out_val_d   = 16'h0000;
          out_last_d  = 1'b0;
          tx_cnt_d    = tx_cnt_q + 3'd1;
          case (tx_cnt_q)
            3'd6: begin
              out_tx_d = crc_q[15:8];
            end
            3'd7: begin
              out_tx_d   = crc_q[7:0];
              out_last_d = 1'b1;
              tx_cnt_d   = 3'd0;
              state_d    = ST_IDLE;
            end
            default: begin
              // Bytes one to five: emit the head of the shift register and fold it into the CRC.
              out_tx_d = tx_sh_q[39:32];
              crc_d    = crc_byte(crc_q, tx_sh_q[39:32]);
              tx_sh_d  = {tx_sh_q[31:0], 8'h00};
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tx_cnt_q    <= 3'd0;
      crc_q       <= CRC_SEED;
      slave_q     <= SLAVE_RESET;
      resp_cnt_q  <= '0;
      resp_func_q <= 8'h00;
      resp_bcnt_q <= 8'h00;
      resp_data_q <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_cnt_q    <= tx_cnt_d;
      crc_q       <= crc_d;
      resp_cnt_q  <= resp_cnt_d;
      resp_func_q <= resp_func_d;
      resp_bcnt_q <= resp_bcnt_d;
      resp_data_q <= resp_data_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slave_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tx_sh_q    <= tx_sh_d;
    out_kind_q <= out_kind_d;
    out_tx_q   <= out_tx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign tx_byte_o    = out_tx_q;
  assign read_value_o = $signed(out_val_q);
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// ----- test/modbus_rtu_register_frame_engine_tb.sv -----
`timescale 1ns / 1ps

module modbus_rtu_register_frame_engine_tb;
  import mbrtu_pkg::*;

  localparam int RESP_LIMIT      = 64;
  localparam int ITEM_TARGET     = 320;
  localparam int PHASES          = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    op_e         op;
    logic [15:0] reg_addr;
    logic [15:0] wval;
    logic [7:0]  rx;
  } request_word_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  tx;
    logic [15:0] value;
    logic        last;
  } result_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [7:0]         cfg_wdata_i = 8'h00;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_WRITE;
  logic [15:0]        register_address_i = 16'h0000;
  logic signed [15:0] write_value_i = 16'sh0000;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [7:0]         tx_byte_o;
  logic signed [15:0] read_value_o;
  logic               last_o;

  modbus_rtu_register_frame_engine #(
    .RESPONSE_LIMIT(RESP_LIMIT)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .register_address_i(register_address_i),
    .write_value_i     (write_value_i),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .tx_byte_o         (tx_byte_o),
    .read_value_o      (read_value_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  request_word_t pending_words[$];
  result_word_t  awaited_results[$];

  int   items_queued = 0;
  int   mismatches = 0;
  int   words_out = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   stall_left = 0;
  int   stall_calm = 0;
  int   hold_left = 0;
  bit   pressure_done = 1'b0;
  logic in_taken = 1'b0;
  logic [7:0] cur_slave = SLAVE_RESET;

  // Engine state as the checker sees it.
  logic [7:0]  eng_slave = SLAVE_RESET;
  int          eng_rx_count = 0;
  logic [7:0]  eng_rx_func = 8'h00;
  logic [7:0]  eng_rx_len = 8'h00;
  logic [15:0] eng_rx_data = 16'h0000;
  logic [15:0] eng_crc = CRC_SEED;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void clear_capture();
    eng_rx_count = 0;
    eng_rx_func = 8'h00;
    eng_rx_len = 8'h00;
    eng_rx_data = 16'h0000;
  endfunction

  // Works out the result words caused by one accepted word and updates the engine state.
  function automatic void predict_engine_words(input request_word_t w);
    logic [7:0]   frame [8];
    logic [15:0]  data;
    result_word_t r;
    case (w.op)
      OP_WRITE, OP_READ: begin
        data = (w.op == OP_WRITE) ? w.wval : READ_COUNT;
        frame[0] = eng_slave;
        frame[1] = (w.op == OP_WRITE) ? FUNC_WRITE : FUNC_READ;
        frame[2] = w.reg_addr[15:8];
        frame[3] = w.reg_addr[7:0];
        frame[4] = data[15:8];
        frame[5] = data[7:0];
        eng_crc = CRC_SEED;
        for (int i = 0; i < 6; i++) begin
          eng_crc = crc16_modbus(eng_crc, frame[i]);
        end
        // The frame carries the CRC high byte first.
        frame[6] = eng_crc[15:8];
        frame[7] = eng_crc[7:0];
        clear_capture();
        for (int i = 0; i < 8; i++) begin
          r.kind = KIND_TX;
          r.tx = frame[i];
          r.value = 16'h0000;
          r.last = (i == 7);
          awaited_results.push_back(r);
        end
      end
      OP_RESP_BYTE: begin
        if (eng_rx_count < RESP_LIMIT) begin
          case (eng_rx_count)
            1: eng_rx_func = w.rx;
            2: eng_rx_len = w.rx;
            3: eng_rx_data[15:8] = w.rx;
            4: eng_rx_data[7:0] = w.rx;
            default: begin
            end
          endcase
          eng_rx_count++;
        end
      end
      default: begin
        r.tx = 8'h00;
        r.last = 1'b1;
        if (eng_rx_count >= 5 && eng_rx_func == FUNC_READ && eng_rx_len == RESP_DATA_BYTES) begin
          r.kind = KIND_VALUE;
          r.value = eng_rx_data;
        end else begin
          r.kind = KIND_INVALID;
          r.value = 16'h0000;
        end
        awaited_results.push_back(r);
        clear_capture();
      end
    endcase
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [15:0] rand16();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'h8000;
    if (r == 3) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  function automatic void push_word(input op_e op, input logic [15:0] a, input logic [15:0] v,
                                    input logic [7:0] b);
    request_word_t w;
    w.op = op;
    w.reg_addr = a;
    w.wval = v;
    w.rx = b;
    pending_words.push_back(w);
    items_queued++;
  endfunction

  // Queues the bytes of one response followed by its end marker.
  function automatic void push_reply(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      push_word(OP_RESP_BYTE, 16'($urandom), 16'($urandom), bytes[i]);
    end
    push_word(OP_RESP_END, 16'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  task automatic wait_idle();
    // Checked at the rising edge, where the driver has settled for the cycle.
    while (pending_words.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    // A trailing response byte leaves no result, so give the engine time to absorb it.
    repeat (4) @(negedge clk_i);
  endtask

  // Word driver.
  always @(negedge clk_i) begin
    request_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        op_i <= w.op;
        register_address_i <= w.reg_addr;
        write_value_i <= w.wval;
        rx_byte_i <= w.rx;
        in_valid_i <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off while the sender still has words queued.
  always @(negedge clk_i) begin
    if (!pressure_done && words_out >= 300 && pending_words.size() > 20) begin
      hold_left = HOLD_OFF_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(stall_calm);
    end
  end

  // Monitor: prediction on input acceptance, checking on output acceptance.
  always @(posedge clk_i) begin
    request_word_t w;
    result_word_t  want;
    logic          out_fire;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && cfg_we_i) begin
      eng_slave = cfg_wdata_i;
    end
    if (in_taken) begin
      w.op = op_e'(op_i);
      w.reg_addr = register_address_i;
      w.wval = write_value_i;
      w.rx = rx_byte_i;
      predict_engine_words(w);
    end
    if (out_fire) begin
      words_out++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected word: kind=%0d tx=%02h value=%04h last=%0b",
                   kind_o, tx_byte_o, read_value_o, last_o);
        end
      end else begin
        want = awaited_results.pop_front();
        if (kind_o !== want.kind || tx_byte_o !== want.tx ||
            read_value_o !== want.value || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("word %0d mismatch: expected kind=%0d tx=%02h value=%04h last=%0b, ",
                   words_out, want.kind, want.tx, want.value, want.last);
            $display("got kind=%0d tx=%02h value=%04h last=%0b",
                     kind_o, tx_byte_o, read_value_o, last_o);
          end
        end
      end
    end
    if (!rst_ni || in_taken || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("modbus_rtu_register_frame_engine_tb failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] reply[$];
    int         choice;
    int         len;
    int         target;
    op_e        op;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words with the reset slave address.
    push_word(OP_WRITE, 16'h0000, 16'h8000, 8'h00);
    push_word(OP_WRITE, 16'hFFFF, 16'h7FFF, 8'hFF);
    push_word(OP_WRITE, 16'h00FF, 16'hFFFF, 8'h00);
    push_word(OP_READ, 16'hFF00, 16'h0000, 8'hFF);
    reply = '{8'h01, FUNC_READ, RESP_DATA_BYTES, 8'h80, 8'h00, 8'hFF, 8'hFF};
    push_reply(reply);
    // End of response with nothing received.
    reply = {};
    push_reply(reply);
    // Exception reply: function code with the error bit set.
    reply = '{8'h01, 8'h83, 8'h02};
    push_reply(reply);
    // Wrong byte count.
    reply = '{8'h01, FUNC_READ, 8'h04, 8'h7F, 8'hFF};
    push_reply(reply);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: cur_slave = 8'h00;
        1: cur_slave = 8'hFF;
        default: cur_slave = 8'($urandom);
      endcase
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= cur_slave;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      target = items_queued + ITEM_TARGET / PHASES;
      while (items_queued < target) begin
        choice = $urandom_range(0, 99);
        reply = '{cur_slave, FUNC_READ, RESP_DATA_BYTES, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom)};
        if (choice < 35) begin
          push_word(OP_READ, rand16(), 16'($urandom), 8'($urandom));
          push_reply(reply);
        end else if (choice < 50) begin
          // A write is answered with a reply that carries the write function code and random bytes.
          push_word(OP_WRITE, rand16(), rand16(), 8'($urandom));
          reply = '{cur_slave, FUNC_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom)};
          push_reply(reply);
        end else if (choice < 60) begin
          op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
          push_word(op, rand16(), rand16(), 8'($urandom));
        end else if (choice < 75) begin
          case ($urandom_range(0, 3))
            0: begin
              len = $urandom_range(0, 4);
              while (reply.size() > len) void'(reply.pop_back());
            end
            1: reply[1] = ($urandom_range(0, 1) == 0) ? 8'h83 : 8'($urandom);
            2: reply[2] = 8'($urandom);
            default: begin
              while (reply.size() > 5) void'(reply.pop_back());
            end
          endcase
          push_reply(reply);
        end else if (choice < 90) begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            push_word(op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom));
          end
        end else if (choice < 93) begin
          // Long reply that can run the byte counter into saturation.
          len = $urandom_range(RESP_LIMIT - 4, RESP_LIMIT + 10);
          while (reply.size() < len) reply.push_back(8'($urandom));
          push_reply(reply);
        end else begin
          push_word(OP_RESP_END, 16'($urandom), 16'($urandom), 8'($urandom));
        end
      end
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", awaited_results.size());
    end
    if (mismatches == 0) begin
      $display("modbus_rtu_register_frame_engine_tb passed");
    end else begin
      $display("modbus_rtu_register_frame_engine_tb failed");
    end
    $finish;
  end

endmodule
